### rtl/core/plr_pkg.sv
// ----------------------------------------------------------------------------
// plr_pkg
// shared types and constants of the pixel to cell line rasterizer
// ----------------------------------------------------------------------------
package plr_pkg;

    // grid cell index width, fixed by the result fields
    localparam int CELL_BITS = 6;
    // cell size register width
    localparam int SIZE_BITS = 8;
    // signed line error width and its doubled form
    localparam int ERR_BITS = 9;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_HEIGHT = 1'd1;

    // cell size after reset
    localparam logic [SIZE_BITS-1:0] DEFAULT_CELL_SIZE = 8'd20;

    // which endpoint coordinate goes through the divider
    typedef logic [1:0] coord_sel_t;
    localparam coord_sel_t SEL_X0 = 2'd0;
    localparam coord_sel_t SEL_Y0 = 2'd1;
    localparam coord_sel_t SEL_X1 = 2'd2;
    localparam coord_sel_t SEL_Y1 = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic       div_store;
        coord_sel_t div_sel;
        logic       init;
        logic       step;
    } plr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic div_busy;
        logic at_goal;
        logic out_free;
    } plr_status_t;

endpackage

### rtl/core/plr_divider.sv
// ----------------------------------------------------------------------------
// plr_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plr_divider #(
    parameter int DVD_BITS = 12,
    parameter int DVS_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                busy,
    output logic                done,
    output logic [DVD_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    logic [DVD_BITS-1:0] quo_reg;
    logic [DVS_BITS-1:0] rem_reg;
    logic [DVS_BITS-1:0] dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DVS_BITS:0]   shifted;
    logic                fits;
    logic [DVS_BITS:0]   diff;

    // remainder stays below the divisor, so the shifted value fits one more bit
    assign shifted = {rem_reg, quo_reg[DVD_BITS-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DVD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_BITS-2:0], fits};
            rem_reg <= fits ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/plr_datapath.sv
// ----------------------------------------------------------------------------
// plr_datapath
// cell size registers, endpoint capture, divider, line stepper, result register
// ----------------------------------------------------------------------------
module plr_datapath import plr_pkg::*; #(
    parameter int GRID_CELLS = 64,
    parameter int PIXEL_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data,
    input  logic [PIXEL_BITS-1:0]     start_px_x,
    input  logic [PIXEL_BITS-1:0]     start_px_y,
    input  logic [PIXEL_BITS-1:0]     end_px_x,
    input  logic [PIXEL_BITS-1:0]     end_px_y,
    input  logic                      cell_value,
    input  logic                      out_stall,
    input  plr_cmd_t                  cmd,
    output plr_status_t               status,
    output logic                      out_valid,
    output logic [CELL_BITS-1:0]      cell_x,
    output logic [CELL_BITS-1:0]      cell_y,
    output logic                      value_out,
    output logic                      last
);

    localparam logic [PIXEL_BITS-1:0] MAX_CELL_PX = PIXEL_BITS'(GRID_CELLS - 1);
    localparam logic [CELL_BITS-1:0]  MAX_CELL    = CELL_BITS'(GRID_CELLS - 1);

    logic [SIZE_BITS-1:0]  cell_width_reg;
    logic [SIZE_BITS-1:0]  cell_height_reg;
    logic [PIXEL_BITS-1:0] px_reg [4];
    logic                  value_reg;

    logic [CELL_BITS-1:0]  cur_x_reg;
    logic [CELL_BITS-1:0]  cur_y_reg;
    logic [CELL_BITS-1:0]  goal_x_reg;
    logic [CELL_BITS-1:0]  goal_y_reg;
    logic signed [ERR_BITS-1:0] dx_reg;
    logic signed [ERR_BITS-1:0] dy_reg;
    logic signed [ERR_BITS-1:0] err_reg;
    logic                  sx_reg;
    logic                  sy_reg;

    logic                  out_valid_reg;
    logic [CELL_BITS-1:0]  out_x_reg;
    logic [CELL_BITS-1:0]  out_y_reg;
    logic                  out_value_reg;
    logic                  out_last_reg;

    logic [SIZE_BITS-1:0]  size_sel;
    logic [SIZE_BITS-1:0]  divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [PIXEL_BITS-1:0] quotient;
    logic [CELL_BITS-1:0]  cell_sat;

    logic [CELL_BITS-1:0]  abs_dx;
    logic [CELL_BITS-1:0]  abs_dy;
    logic signed [ERR_BITS-1:0] dx_init;
    logic signed [ERR_BITS-1:0] dy_init;

    logic signed [ERR_BITS:0]   e2;
    logic signed [ERR_BITS:0]   dx_ext;
    logic signed [ERR_BITS:0]   dy_ext;
    logic                  move_x;
    logic                  move_y;
    logic signed [ERR_BITS-1:0] err_next;
    logic                  at_goal;

    // cell size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= DEFAULT_CELL_SIZE;
            cell_height_reg <= DEFAULT_CELL_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // endpoint capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg[SEL_X0] <= start_px_x;
            px_reg[SEL_Y0] <= start_px_y;
            px_reg[SEL_X1] <= end_px_x;
            px_reg[SEL_Y1] <= end_px_y;
            value_reg      <= cell_value;
        end
    end

    // pixel to cell division, zero size acts as one
    assign size_sel = (cmd.div_sel == SEL_X0 || cmd.div_sel == SEL_X1)
                    ? cell_width_reg : cell_height_reg;
    assign divisor  = (size_sel == '0) ? SIZE_BITS'(1) : size_sel;

    plr_divider #(
        .DVD_BITS (PIXEL_BITS),
        .DVS_BITS (SIZE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (px_reg[cmd.div_sel]),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cell_sat = (quotient > MAX_CELL_PX) ? MAX_CELL : quotient[CELL_BITS-1:0];

    // line setup
    assign abs_dx  = (goal_x_reg > cur_x_reg) ? (goal_x_reg - cur_x_reg)
                                               : (cur_x_reg - goal_x_reg);
    assign abs_dy  = (goal_y_reg > cur_y_reg) ? (goal_y_reg - cur_y_reg)
                                               : (cur_y_reg - goal_y_reg);
    assign dx_init = ERR_BITS'(abs_dx);
    assign dy_init = -ERR_BITS'(abs_dy);

    // one stepper move
    assign e2       = {err_reg, 1'b0};
    assign dx_ext   = {dx_reg[ERR_BITS-1], dx_reg};
    assign dy_ext   = {dy_reg[ERR_BITS-1], dy_reg};
    assign move_x   = (e2 >= dy_ext);
    assign move_y   = (e2 <= dx_ext);
    assign err_next = err_reg + (move_x ? dy_reg : '0) + (move_y ? dx_reg : '0);
    assign at_goal  = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            err_reg    <= '0;
        end
        else
        begin
            if (cmd.div_store)
            begin
                unique case (cmd.div_sel)
                    SEL_X0:  cur_x_reg  <= cell_sat;
                    SEL_Y0:  cur_y_reg  <= cell_sat;
                    SEL_X1:  goal_x_reg <= cell_sat;
                    SEL_Y1:  goal_y_reg <= cell_sat;
                    default: ;
                endcase
            end
            if (cmd.init)
            begin
                err_reg <= dx_init + dy_init;
            end
            // the end cell stays put once it is sent
            if (cmd.step && !at_goal)
            begin
                err_reg <= err_next;
                if (move_x)
                begin
                    cur_x_reg <= sx_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1;
                end
                if (move_y)
                begin
                    cur_y_reg <= sy_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            dx_reg <= dx_init;
            dy_reg <= dy_init;
            sx_reg <= (cur_x_reg < goal_x_reg);
            sy_reg <= (cur_y_reg < goal_y_reg);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_value_reg <= value_reg;
            out_last_reg  <= at_goal;
        end
    end

    assign status.div_done = div_done;
    assign status.div_busy = div_busy;
    assign status.at_goal  = at_goal;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign cell_x    = out_x_reg;
    assign cell_y    = out_y_reg;
    assign value_out = out_value_reg;
    assign last      = out_last_reg;

endmodule

### rtl/core/plr_ctrl.sv
// ----------------------------------------------------------------------------
// plr_ctrl
// sequencer: four divisions, line setup, then one cell per free output slot
// ----------------------------------------------------------------------------
module plr_ctrl import plr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  plr_status_t status,
    output plr_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_START = 3'd1;
    localparam logic [2:0] S_DIV_WAIT  = 3'd2;
    localparam logic [2:0] S_INIT      = 3'd3;
    localparam logic [2:0] S_STEP      = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    coord_sel_t sel_reg;
    coord_sel_t sel_next;

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    sel_next    = SEL_X0;
                    state_next  = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == SEL_Y1)
                    begin
                        state_next = S_INIT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.at_goal)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_X0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### rtl/core/pixel_to_cell_line_rasterizer.sv
// ----------------------------------------------------------------------------
// pixel_to_cell_line_rasterizer
// maps two pixel endpoints to grid cells and walks the cell line between them
// ----------------------------------------------------------------------------
// the four pixel to cell divisions share one restoring divider that makes one
// quotient bit per cycle; line setup follows them, then the first cell
// a new item is taken only after the last cell of the line has been issued,
// and cells leave at one per cycle while the output is not stalled
// reset: async active low; returns to idle, cell sizes to 20, stepper to zero
// ----------------------------------------------------------------------------
module pixel_to_cell_line_rasterizer import plr_pkg::*; #(
    parameter int GRID_CELLS = 64,
    parameter int PIXEL_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data,
    // input item channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [PIXEL_BITS-1:0]     start_px_x,
    input  logic [PIXEL_BITS-1:0]     start_px_y,
    input  logic [PIXEL_BITS-1:0]     end_px_x,
    input  logic [PIXEL_BITS-1:0]     end_px_y,
    input  logic                      cell_value,
    // result channel, one transfer per cell on the line
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CELL_BITS-1:0]      cell_x,
    output logic [CELL_BITS-1:0]      cell_y,
    output logic                      value_out,
    output logic                      last
);

    plr_cmd_t    cmd;
    plr_status_t status;

    // sequencer: accepts an item only when idle, then runs the divisions,
    // line setup and one stepper move per free output slot
    plr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: size registers, shared divider with saturation at the grid
    // edge, line stepper and the result register that decouples the output
    plr_datapath #(
        .GRID_CELLS (GRID_CELLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start_px_x (start_px_x),
        .start_px_y (start_px_y),
        .end_px_x   (end_px_x),
        .end_px_y   (end_px_y),
        .cell_value (cell_value),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .value_out  (value_out),
        .last       (last)
    );

`ifndef ASSERT_OFF
    // an accepted item keeps the block busy for the divisions
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a transfer");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> status.out_free)
        else $error("stepper advanced into a stalled result");

    // divider is quiet while the block is idle
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!status.div_busy && !status.div_done))
        else $error("divider active while idle");

    // the final cell of a line hands control back to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.at_goal) |=> (!in_stall && out_valid && last))
        else $error("end cell did not close the line");
`endif

endmodule
